// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL that checks itself.
// Each macro expects clk and rst_n in scope; checks are off while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DTP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dtp_pkg.sv -----
// Package for the digit text pixel generator: geometry constants, opcodes,
// request/response structs and config geometry helpers. No dependencies.
`timescale 1ns / 1ps

package dtp_pkg;

    localparam int MAX_LINES   = 16;
    localparam int MAX_CHARS   = 64;
    localparam int GLYPH_COLS  = 10;
    localparam int GLYPH_ROWS  = 8;
    localparam int DIGITS      = 10;
    localparam int MARGIN      = 2;
    localparam int LINE_GAP    = 2;
    localparam int PITCH       = GLYPH_ROWS + LINE_GAP;

    localparam int LINE_W      = $clog2(MAX_LINES);
    localparam int POS_W       = $clog2(MAX_CHARS);
    localparam int TEXT_AW     = LINE_W + POS_W;
    localparam int TEXT_DEPTH  = MAX_LINES * MAX_CHARS;
    localparam int GLYPH_DEPTH = DIGITS * GLYPH_COLS;
    localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);
    localparam int DIGIT_W     = 4;
    localparam int GCOL_W      = 4;
    localparam int BIT_W       = $clog2(GLYPH_ROWS);
    localparam int ROW_W       = 8;
    localparam int COL_W       = 10;
    localparam int CHAR_W      = 8;
    localparam int PIX_W       = 8;
    localparam int LCNT_W      = 5;
    localparam int LLEN_W      = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    // x / 10 == (x * 205) >> 11 for every x below 1029
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_SHIFT = 11;
    localparam int MUL_W       = 8;

    localparam logic [PIX_W-1:0]  PAPER     = 8'hFF;
    localparam logic [PIX_W-1:0]  INK       = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'd57;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITALIC      = 2'd2;

    typedef enum logic [1:0] {
        OP_GLYPH = 2'd0,
        OP_TEXT  = 2'd1,
        OP_PIXEL = 2'd2,
        OP_NOP   = 2'd3
    } dtp_op_t;

    // pixel class carried down the pipe
    typedef enum logic [1:0] {
        PX_OOB,
        PX_PAD,
        PX_PAPER,
        PX_CELL
    } dtp_kind_t;

    typedef struct packed {
        dtp_op_t               op;
        logic [DIGIT_W-1:0]    digit_index;
        logic [GCOL_W-1:0]     glyph_column;
        logic [GLYPH_ROWS-1:0] glyph_bits;
        logic [LINE_W-1:0]     text_line;
        logic [POS_W-1:0]      text_position;
        logic [CHAR_W-1:0]     char_code;
        logic [ROW_W-1:0]      pixel_row;
        logic [COL_W-1:0]      pixel_column;
    } dtp_req_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             out_of_image;
    } dtp_rsp_t;

    // image geometry derived from the config registers
    typedef struct packed {
        logic [COL_W-1:0] width;
        logic [COL_W-1:0] row_bytes;
        logic [ROW_W-1:0] height;
        logic             italic;
    } dtp_geom_t;

    function automatic logic [COL_W-1:0] image_width(input logic [LLEN_W-1:0] len_raw);
        logic [LLEN_W-1:0] len;
        logic [COL_W-1:0]  len_x;
        len = len_raw;
        if (len_raw == '0)
            len = LLEN_W'(1);
        else if (len_raw > LLEN_W'(MAX_CHARS))
            len = LLEN_W'(MAX_CHARS);
        len_x = COL_W'(len);
        return (len_x << 3) + (len_x << 1) + COL_W'(2 * MARGIN);
    endfunction

    function automatic logic [COL_W-1:0] image_row_bytes(input logic [COL_W-1:0] width);
        logic [COL_W-1:0] up;
        up = width + COL_W'(3);
        return {up[COL_W-1:2], 2'b00};
    endfunction

    function automatic logic [ROW_W-1:0] image_height(input logic [LCNT_W-1:0] cnt_raw);
        logic [LCNT_W-1:0] cnt;
        logic [ROW_W-1:0]  cnt_x;
        cnt = cnt_raw;
        if (cnt_raw == '0)
            cnt = LCNT_W'(1);
        else if (cnt_raw > LCNT_W'(MAX_LINES))
            cnt = LCNT_W'(MAX_LINES);
        cnt_x = ROW_W'(cnt);
        return (cnt_x << 3) + (cnt_x << 1) + ROW_W'(MARGIN);
    endfunction

endpackage

// ----- hw/rtl/digit_text_pixel_generator.sv -----
// Top level of the digit text pixel generator: four-stage request pipeline plus
// output register. Depends on dtp_pkg, dtp_cfg, dtp_text_store, dtp_glyph_store.
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel | signals                          | direction | payload
//  --------+----------------------------------+-----------+----------------------------
//  req     | req_valid, req_ready, req        | in        | dtp_req_t (op + fields)
//  pix     | pix_valid, pix_ready, pix        | out       | dtp_rsp_t (pixel, oob flag)
//  cfg     | cfg_valid, cfg_ready, cfg_index, | in        | register index, write data
//          | cfg_data                         |           |
//
//  One request per cycle sustained while pix is not stalled. A pixel request passes
//  s1, s2 (text read), s3 (glyph read), s4 and the output register to reach pix.
//  After reset the text store is cleared one entry per cycle: req_ready stays
//  low until all TEXT_DEPTH (1024) entries are clear; cfg writes are always taken.
//  A stalled pix only blocks req once every pipe stage holds a request;
//  load requests make no pix, and one in s4 drains past a stalled output.

module digit_text_pixel_generator
    import dtp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  dtp_req_t              req,
    output logic                  pix_valid,
    input  logic                  pix_ready,
    output dtp_rsp_t              pix,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PROD_R_W = ROW_W + MUL_W;
    localparam int PROD_C_W = COL_W + MUL_W;
    localparam int QR_W     = PROD_R_W - DIV10_SHIFT;
    localparam int QC_W     = PROD_C_W - DIV10_SHIFT;

    dtp_geom_t geom;
    logic      clear_done;

    // stage enables, ripple back from the output register
    logic out_free;
    logic en1;
    logic en2;
    logic en3;
    logic en4;

    // ---------------- stage 1: request register, bounds and divide-by-10 products
    logic                s1_valid_reg;
    dtp_req_t            s1_req_reg;
    logic                s1_oob;
    logic                s1_pad;
    logic                s1_edge;
    logic [COL_W-1:0]    s1_cx;
    logic [PROD_R_W-1:0] s1_prod_r;
    logic [PROD_C_W-1:0] s1_prod_c;

    // ---------------- stage 2: remainders, glyph coordinate, text read
    logic              s2_valid_reg;
    dtp_req_t          s2_req_reg;
    logic              s2_oob_reg;
    logic              s2_pad_reg;
    logic              s2_edge_reg;
    logic [QR_W-1:0]   s2_line_q_reg;
    logic [QC_W-1:0]   s2_pos_q_reg;
    logic [COL_W-1:0]  s2_cx_reg;
    logic [ROW_W-1:0]  s2_line10;
    logic [ROW_W-1:0]  s2_rem_r8;
    logic [COL_W-1:0]  s2_pos10;
    logic [COL_W-1:0]  s2_rem_c10;
    logic [3:0]        s2_rem_r;
    logic [3:0]        s2_rem_c;
    logic              s2_gap;
    logic [BIT_W-1:0]  s2_cy;
    logic [BIT_W-1:0]  s2_bit;
    logic [GCOL_W-1:0] s2_g1;
    logic [GCOL_W-1:0] s2_gp;
    logic              s2_gcol_ok;
    logic [GCOL_W-1:0] s2_gcol;
    dtp_kind_t         s2_kind;
    logic              text_wr_en;
    logic [CHAR_W-1:0] text_rd_data;

    // ---------------- stage 3: character check, glyph read
    logic              s3_valid_reg;
    dtp_req_t          s3_req_reg;
    dtp_kind_t         s3_kind_reg;
    logic [BIT_W-1:0]  s3_bit_reg;
    logic [GCOL_W-1:0] s3_gcol_reg;
    logic              s3_is_digit;
    dtp_kind_t         s3_kind;
    logic              glyph_wr_en;
    logic [GLYPH_ROWS-1:0] glyph_rd_data;

    // ---------------- stage 4: bit pick, output register
    logic             s4_valid_reg;
    logic             s4_pix_reg;
    dtp_kind_t        s4_kind_reg;
    logic [BIT_W-1:0] s4_bit_reg;
    dtp_rsp_t         s4_rsp;
    logic             pix_valid_reg;
    dtp_rsp_t         pix_reg;

    dtp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    assign cfg_ready = 1'b1;

    // stall chain: a stage loads when empty or when its content moves on
    assign out_free  = !pix_valid_reg || pix_ready;
    assign en4       = !s4_valid_reg || !s4_pix_reg || out_free;
    assign en3       = !s3_valid_reg || en4;
    assign en2       = !s2_valid_reg || en3;
    assign en1       = !s1_valid_reg || en2;
    assign req_ready = en1 && clear_done;

    // ---------------- stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en1)
            s1_valid_reg <= req_valid && req_ready;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
            s1_req_reg <= req;
    end

    assign s1_oob  = (s1_req_reg.pixel_row >= geom.height)
                  || (s1_req_reg.pixel_column >= geom.row_bytes);
    assign s1_pad  = s1_req_reg.pixel_column >= geom.width;
    assign s1_edge = (s1_req_reg.pixel_column < COL_W'(MARGIN))
                  || (s1_req_reg.pixel_column >= geom.width - COL_W'(MARGIN));
    assign s1_cx   = s1_req_reg.pixel_column - COL_W'(MARGIN);

    // reciprocal multiply: row / 10 gives the text line, (col - 2) / 10 the position.
    // The row test for a gap uses row % 10, so line = row / 10 inside a cell.
    assign s1_prod_r = PROD_R_W'(s1_req_reg.pixel_row) * PROD_R_W'(DIV10_MUL);
    assign s1_prod_c = PROD_C_W'(s1_cx) * PROD_C_W'(DIV10_MUL);

    // ---------------- stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_req_reg    <= s1_req_reg;
            s2_oob_reg    <= s1_oob;
            s2_pad_reg    <= s1_pad;
            s2_edge_reg   <= s1_edge;
            s2_line_q_reg <= s1_prod_r[PROD_R_W-1:DIV10_SHIFT];
            s2_pos_q_reg  <= s1_prod_c[PROD_C_W-1:DIV10_SHIFT];
            s2_cx_reg     <= s1_cx;
        end
    end

    // q * 10 as shift-add
    assign s2_line10  = (ROW_W'(s2_line_q_reg) << 3) + (ROW_W'(s2_line_q_reg) << 1);
    assign s2_rem_r8  = s2_req_reg.pixel_row - s2_line10;
    assign s2_rem_r   = s2_rem_r8[3:0];
    assign s2_pos10   = (COL_W'(s2_pos_q_reg) << 3) + (COL_W'(s2_pos_q_reg) << 1);
    assign s2_rem_c10 = s2_cx_reg - s2_pos10;
    assign s2_rem_c   = s2_rem_c10[3:0];

    assign s2_gap = s2_rem_r < 4'(MARGIN);
    assign s2_cy  = BIT_W'(s2_rem_r - 4'(MARGIN));
    assign s2_bit = BIT_W'(GLYPH_ROWS - 1) - s2_cy;
    // glyph column plus one, so an italic shift left of column zero stays unsigned
    assign s2_g1  = GCOL_W'(GLYPH_COLS) - s2_rem_c;

    always_comb
    begin
        s2_gp = s2_g1;
        if (geom.italic)
        begin
            priority if (s2_bit < BIT_W'(3))
                s2_gp = s2_g1 - GCOL_W'(1);
            else if (s2_bit > BIT_W'(4))
                s2_gp = s2_g1 + GCOL_W'(1);
            else
                s2_gp = s2_g1;
        end
    end

    assign s2_gcol_ok = (s2_gp != '0) && (s2_gp <= GCOL_W'(GLYPH_COLS));
    assign s2_gcol    = s2_gp - GCOL_W'(1);

    always_comb
    begin
        priority if (s2_oob_reg)
            s2_kind = PX_OOB;
        else if (s2_pad_reg)
            s2_kind = PX_PAD;
        else if (s2_edge_reg || s2_gap || !s2_gcol_ok)
            s2_kind = PX_PAPER;
        else
            s2_kind = PX_CELL;
    end

    // text writes and reads both happen here, so they stay in request order
    assign text_wr_en = s2_valid_reg && en3 && (s2_req_reg.op == OP_TEXT);

    dtp_text_store u_text (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (text_wr_en),
        .wr_addr    ({s2_req_reg.text_line, s2_req_reg.text_position}),
        .wr_data    (s2_req_reg.char_code),
        .rd_en      (en3),
        .rd_addr    ({s2_line_q_reg[LINE_W-1:0], s2_pos_q_reg[POS_W-1:0]}),
        .rd_data    (text_rd_data),
        .clear_done (clear_done)
    );

    // ---------------- stage 3
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en3)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_req_reg  <= s2_req_reg;
            s3_kind_reg <= s2_kind;
            s3_bit_reg  <= s2_bit;
            s3_gcol_reg <= s2_gcol;
        end
    end

    // blank (code zero) and any non-digit code render as background
    assign s3_is_digit = (text_rd_data >= CHAR_ZERO) && (text_rd_data <= CHAR_NINE);
    assign s3_kind     = ((s3_kind_reg == PX_CELL) && !s3_is_digit) ? PX_PAPER : s3_kind_reg;
    assign glyph_wr_en = s3_valid_reg && en4 && (s3_req_reg.op == OP_GLYPH);

    // digit codes are 0x30..0x39, so the low nibble is the digit
    dtp_glyph_store u_glyph (
        .clk      (clk),
        .wr_en    (glyph_wr_en),
        .wr_digit (s3_req_reg.digit_index),
        .wr_col   (s3_req_reg.glyph_column),
        .wr_data  (s3_req_reg.glyph_bits),
        .rd_en    (en4),
        .rd_digit (text_rd_data[DIGIT_W-1:0]),
        .rd_col   (s3_gcol_reg),
        .rd_data  (glyph_rd_data)
    );

    // ---------------- stage 4
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (en4)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_pix_reg  <= s3_req_reg.op == OP_PIXEL;
            s4_kind_reg <= s3_kind;
            s4_bit_reg  <= s3_bit_reg;
        end
    end

    always_comb
    begin
        s4_rsp.out_of_image = 1'b0;
        unique case (s4_kind_reg)
            PX_OOB:
            begin
                s4_rsp.pixel_value  = INK;
                s4_rsp.out_of_image = 1'b1;
            end
            PX_PAD:
            begin
                s4_rsp.pixel_value = INK;
            end
            PX_PAPER:
            begin
                s4_rsp.pixel_value = PAPER;
            end
            PX_CELL:
            begin
                s4_rsp.pixel_value = glyph_rd_data[s4_bit_reg] ? INK : PAPER;
            end
            default:
            begin
                s4_rsp.pixel_value = PAPER;
            end
        endcase
    end

    // ---------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_valid_reg <= 1'b0;
        else if (out_free)
            pix_valid_reg <= s4_valid_reg && s4_pix_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            pix_reg <= s4_rsp;
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    // ---------------- checks
    `DTP_ASSERT_NOW(a_no_req_during_clear, !clear_done, !req_ready, "req taken during clear")
    `DTP_ASSERT_NEXT(a_req_enters_s1, req_valid && req_ready, s1_valid_reg, "req lost at s1")
    `DTP_ASSERT_NOW(a_oob_is_ink, pix_valid && pix.out_of_image, pix.pixel_value == INK, "oob not 0")

endmodule

// ----- hw/rtl/dtp_cfg.sv -----
// Config registers, kept as ready-made image geometry (width, padded row, height, italic).
// Depends on dtp_pkg.
`timescale 1ns / 1ps

module dtp_cfg
    import dtp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output dtp_geom_t             geom
);

    dtp_geom_t geom_reg;
    dtp_geom_t geom_next;
    logic [COL_W-1:0] new_width;

    assign new_width = image_width(cfg_data[LLEN_W-1:0]);

    always_comb
    begin
        geom_next = geom_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LINE_COUNT:
                begin
                    geom_next.height = image_height(cfg_data[LCNT_W-1:0]);
                end
                CFG_LINE_LENGTH:
                begin
                    geom_next.width     = new_width;
                    geom_next.row_bytes = image_row_bytes(new_width);
                end
                CFG_ITALIC:
                begin
                    geom_next.italic = cfg_data[0];
                end
                default:
                begin
                    geom_next = geom_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.width     <= image_width(LLEN_W'(1));
            geom_reg.row_bytes <= image_row_bytes(image_width(LLEN_W'(1)));
            geom_reg.height    <= image_height(LCNT_W'(1));
            geom_reg.italic    <= 1'b1;
        end
        else
        begin
            geom_reg <= geom_next;
        end
    end

    assign geom = geom_reg;

endmodule

// ----- hw/rtl/dtp_text_store.sv -----
// Text character memory, one byte per line/position, with a clear sweep after reset.
// Depends on dtp_pkg.
`timescale 1ns / 1ps

module dtp_text_store
    import dtp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [TEXT_AW-1:0] wr_addr,
    input  logic [CHAR_W-1:0]  wr_data,
    input  logic               rd_en,
    input  logic [TEXT_AW-1:0] rd_addr,
    output logic [CHAR_W-1:0]  rd_data,
    output logic               clear_done
);

    logic [CHAR_W-1:0] mem [TEXT_DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;
    logic [TEXT_AW:0]  clr_cnt_reg;
    logic [TEXT_AW:0]  clr_cnt_next;

    assign clear_done   = clr_cnt_reg[TEXT_AW];
    assign clr_cnt_next = clear_done ? clr_cnt_reg : clr_cnt_reg + (TEXT_AW + 1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else
            clr_cnt_reg <= clr_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (!clear_done)
            mem[clr_cnt_reg[TEXT_AW-1:0]] <= '0;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/dtp_glyph_store.sv -----
// Digit glyph memory: ten digits by GLYPH_COLS column bytes, addressed by digit and column.
// Depends on dtp_pkg.
`timescale 1ns / 1ps

module dtp_glyph_store
    import dtp_pkg::*;
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [DIGIT_W-1:0]    wr_digit,
    input  logic [GCOL_W-1:0]     wr_col,
    input  logic [GLYPH_ROWS-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [DIGIT_W-1:0]    rd_digit,
    input  logic [GCOL_W-1:0]     rd_col,
    output logic [GLYPH_ROWS-1:0] rd_data
);

    logic [GLYPH_ROWS-1:0] mem [GLYPH_DEPTH];
    logic [GLYPH_ROWS-1:0] rd_data_reg;
    logic [GLYPH_AW-1:0]   wr_addr;
    logic [GLYPH_AW-1:0]   rd_addr;
    logic                  wr_ok;

    // digit * 10 + column
    assign wr_addr = (GLYPH_AW'(wr_digit) << 3) + (GLYPH_AW'(wr_digit) << 1)
                   + GLYPH_AW'(wr_col);
    assign rd_addr = (GLYPH_AW'(rd_digit) << 3) + (GLYPH_AW'(rd_digit) << 1)
                   + GLYPH_AW'(rd_col);
    // out-of-range loads are dropped
    assign wr_ok   = (wr_digit < DIGIT_W'(DIGITS)) && (wr_col < GCOL_W'(GLYPH_COLS));

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_ok)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
